### hw/rtl/sliding_window_sender_control_macros.svh
// ----------------------------------------------------------------------------
// sliding window sender control - assertion macros
// shared property templates for the sender control block, clocked on clk_i
// and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_SENDER_CONTROL_MACROS_SVH
`define SLIDING_WINDOW_SENDER_CONTROL_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SWSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SWSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/swsc_pkg.sv
// ----------------------------------------------------------------------------
// swsc_pkg
// shared types, codes and reset values for the sliding window sender control
// ----------------------------------------------------------------------------
package swsc_pkg;

  // default parameter values
  localparam int unsigned WindowMaxDef = 1024;
  localparam int unsigned TimeBitsDef  = 32;

  // port widths
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned SDataW   = 80;
  localparam int unsigned MDataW   = 104;

  // result bit positions inside m_axis_tdata
  localparam int unsigned OutRefusedBit = 32;
  localparam int unsigned OutAbortBit   = 97;

  // register reset values
  localparam logic [10:0] WinSizeRst    = 11'd16;
  localparam logic [7:0]  MaxRetriesRst = 8'd50;
  localparam logic [8:0]  RttGainRst    = 9'd32;
  localparam logic [8:0]  DevGainRst    = 9'd64;
  localparam logic [19:0] DevFloorRst   = 20'd10000;
  localparam logic [31:0] InitRtoRst    = 32'd1000000;
  localparam logic [10:0] InitCreditRst = 11'd16;

  // arithmetic constants
  localparam logic [8:0] GainOne    = 9'd256;
  localparam logic [7:0] RoundHalf  = 8'd128;
  localparam logic [7:0] DupFastRtx = 8'd3;
  localparam logic [7:0] CountMax   = 8'hFF;

  // event kinds
  typedef enum logic [1:0] {
    MODE_SEND = 2'd0,
    MODE_ACK  = 2'd1,
    MODE_TICK = 2'd2,
    MODE_NOP  = 2'd3
  } mode_e;

  // result actions
  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_NEW     = 2'd1,
    ACT_TIMEOUT = 2'd2,
    ACT_FAST    = 2'd3
  } action_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW_SIZE    = 3'd0,
    CFG_MAX_RETRIES    = 3'd1,
    CFG_RTT_GAIN       = 3'd2,
    CFG_DEV_GAIN       = 3'd3,
    CFG_DEV_FLOOR      = 3'd4,
    CFG_INITIAL_RTO    = 3'd5,
    CFG_INITIAL_CREDIT = 3'd6
  } cfg_idx_e;

  // datapath steps ordered by the controller
  typedef enum logic [3:0] {
    STEP_IDLE     = 4'd0,
    STEP_EXEC     = 4'd1,
    STEP_TICK_CHK = 4'd2,
    STEP_MOD_MUL  = 4'd3,
    STEP_MOD_SUB  = 4'd4,
    STEP_MOD_FIX  = 4'd5,
    STEP_RTT_RD   = 4'd6,
    STEP_RTT_SMP  = 4'd7,
    STEP_RTT_M1   = 4'd8,
    STEP_RTT_A1   = 4'd9,
    STEP_RTT_D1   = 4'd10,
    STEP_RTT_M2   = 4'd11,
    STEP_RTT_A2   = 4'd12,
    STEP_RTT_RTO  = 4'd13
  } step_e;

  // controller to datapath
  typedef struct packed {
    logic  load;
    step_e step;
    logic  out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic new_ack;
    logic retry_zero;
  } sts_t;

endpackage

### hw/rtl/swsc_ctrl.sv
// ----------------------------------------------------------------------------
// swsc_ctrl
// sequencer for the sender control: accepts one request, steps the datapath
// through the event and hands the result to the output register
// ----------------------------------------------------------------------------
module swsc_ctrl import swsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid_i,
  output logic s_tready_o,
  output logic m_tvalid_o,
  input  logic m_tready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK_CHK,
    ST_MOD_MUL,
    ST_MOD_SUB,
    ST_MOD_FIX,
    ST_RTT_RD,
    ST_RTT_SMP,
    ST_RTT_M1,
    ST_RTT_A1,
    ST_RTT_D1,
    ST_RTT_M2,
    ST_RTT_A2,
    ST_RTT_RTO,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   m_valid_q;
  logic   out_free;

  // handshakes
  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = m_valid_q;
  assign out_free   = !m_valid_q || m_tready_i;

  // command decode
  always_comb begin
    cmd_o.load     = (state_q == ST_IDLE) && s_tvalid_i;
    cmd_o.out_load = (state_q == ST_OUT) && out_free;
    case (state_q)
      ST_EXEC:     cmd_o.step = STEP_EXEC;
      ST_TICK_CHK: cmd_o.step = STEP_TICK_CHK;
      ST_MOD_MUL:  cmd_o.step = STEP_MOD_MUL;
      ST_MOD_SUB:  cmd_o.step = STEP_MOD_SUB;
      ST_MOD_FIX:  cmd_o.step = STEP_MOD_FIX;
      ST_RTT_RD:   cmd_o.step = STEP_RTT_RD;
      ST_RTT_SMP:  cmd_o.step = STEP_RTT_SMP;
      ST_RTT_M1:   cmd_o.step = STEP_RTT_M1;
      ST_RTT_A1:   cmd_o.step = STEP_RTT_A1;
      ST_RTT_D1:   cmd_o.step = STEP_RTT_D1;
      ST_RTT_M2:   cmd_o.step = STEP_RTT_M2;
      ST_RTT_A2:   cmd_o.step = STEP_RTT_A2;
      ST_RTT_RTO:  cmd_o.step = STEP_RTT_RTO;
      default:     cmd_o.step = STEP_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      // set when a result is loaded, cleared when taken
      if ((state_q == ST_OUT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (sts_i.is_tick) begin
            state_q <= ST_TICK_CHK;
          end else if (sts_i.new_ack) begin
            state_q <= ST_MOD_MUL;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_TICK_CHK: state_q <= ST_OUT;
        ST_MOD_MUL:  state_q <= ST_MOD_SUB;
        ST_MOD_SUB:  state_q <= ST_MOD_FIX;
        ST_MOD_FIX: begin
          // rtt sample only when the base packet was never retried
          state_q <= sts_i.retry_zero ? ST_RTT_RD : ST_OUT;
        end
        ST_RTT_RD:   state_q <= ST_RTT_SMP;
        ST_RTT_SMP:  state_q <= ST_RTT_M1;
        ST_RTT_M1:   state_q <= ST_RTT_A1;
        ST_RTT_A1:   state_q <= ST_RTT_D1;
        ST_RTT_D1:   state_q <= ST_RTT_M2;
        ST_RTT_M2:   state_q <= ST_RTT_A2;
        ST_RTT_A2:   state_q <= ST_RTT_RTO;
        ST_RTT_RTO:  state_q <= ST_OUT;
        ST_OUT: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/swsc_dp.sv
// ----------------------------------------------------------------------------
// swsc_dp
// sender datapath: sequence state, send time memory, slot reduction,
// jacobson rtt/rto arithmetic, configuration registers and result register
// ----------------------------------------------------------------------------
module swsc_dp import swsc_pkg::*; #(
  parameter int unsigned WINDOW_MAX = WindowMaxDef,
  parameter int unsigned TIME_BITS  = TimeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [SDataW-1:0]   s_tdata_i,
  input  logic [1:0]          s_tuser_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic [MDataW-1:0]   m_tdata_o,
  output logic [1:0]          m_tuser_o
);

  localparam int unsigned SlotW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned RemW  = $clog2(WINDOW_MAX) + 2;
  localparam logic [SlotW-1:0] LastSlot  = SlotW'(WINDOW_MAX - 1);
  localparam logic [RemW-1:0]  WinMaxRem = RemW'(WINDOW_MAX);
  localparam logic [16:0]      WinMax17  = 17'(WINDOW_MAX);
  localparam logic [31:0]      WinMax32  = 32'(WINDOW_MAX);
  localparam logic [32:0]      Recip     = 33'((64'd1 << 32) / WINDOW_MAX);
  localparam int unsigned      PadW      = MDataW - 98;

  // saturate a time difference to 32 bits
  function automatic logic [31:0] sat32(input logic [TIME_BITS-1:0] v);
    logic [TIME_BITS+31:0] wide;
    wide = {32'd0, v};
    return (wide[TIME_BITS+31:32] != '0) ? 32'hFFFF_FFFF : wide[31:0];
  endfunction

  // latched request
  mode_e       mode_q;
  logic [31:0] ack_q;
  logic [15:0] rwin_q;
  logic [31:0] now_q;

  // configuration
  logic [10:0] win_q, win_d;
  logic [7:0]  max_retries_q, max_retries_d;
  logic [8:0]  rtt_gain_q, rtt_gain_d;
  logic [8:0]  dev_gain_q, dev_gain_d;
  logic [19:0] dev_floor_q, dev_floor_d;

  // sender state
  logic [31:0]      next_seq_q, next_seq_d;
  logic [31:0]      base_seq_q, base_seq_d;
  logic [31:0]      limit_q, limit_d;
  logic [31:0]      srtt_q, srtt_d;
  logic [31:0]      dev_q, dev_d;
  logic [31:0]      rto_q, rto_d;
  logic [7:0]       retry_q, retry_d;
  logic [7:0]       dup_q, dup_d;
  logic             abort_q, abort_d;
  logic [SlotW-1:0] next_slot_q, next_slot_d;
  logic [SlotW-1:0] base_slot_q, base_slot_d;

  // result fields
  action_e     act_q, act_d;
  logic [31:0] tx_q, tx_d;
  logic        refused_q, refused_d;

  // send time memory
  logic [TIME_BITS-1:0] send_times_q [WINDOW_MAX];
  logic [TIME_BITS-1:0] rd_data_q;
  logic                 wr_en, rd_en;
  logic [SlotW-1:0]     wr_addr, rd_addr;

  // arithmetic temporaries
  logic [31:0]     quot_q;
  logic [RemW-1:0] rem_q;
  logic [31:0]     sample_q, diff_q;
  logic [40:0]     pa_q, pb_q;

  logic [TIME_BITS-1:0] now_t;
  logic [64:0]          mod_prod;
  logic [31:0]          quot_w;
  logic [RemW-1:0]      rem_fix;
  logic [SlotW-1:0]     prev_slot;
  logic [16:0]          win_cl;
  logic [15:0]          eff_win;
  logic [31:0]          ack_lim;
  logic [7:0]           retry_inc, dup_inc;
  logic                 retry_over;
  logic [8:0]           gain_g, inv_g, gain_h, inv_h;
  logic [41:0]          blend_sum;
  logic [31:0]          floor_v;
  logic [34:0]          rto_w;
  logic [31:0]          rto_sat;
  logic [31:0]          elapsed;

  assign now_t = TIME_BITS'(now_q);

  // status to the sequencer
  assign sts_o.is_tick    = (mode_q == MODE_TICK);
  assign sts_o.new_ack    = (mode_q == MODE_ACK) && (ack_q > base_seq_q);
  assign sts_o.retry_zero = (retry_q == '0);

  // slot reduction of the ack by reciprocal multiply and one correction
  assign mod_prod  = 65'(ack_q) * 65'(Recip);
  assign quot_w    = quot_q * WinMax32;
  assign rem_fix   = (rem_q >= WinMaxRem) ? (rem_q - WinMaxRem) : rem_q;
  assign prev_slot = (base_slot_q == '0) ? LastSlot : (base_slot_q - 1'b1);

  // effective window and new release limit
  assign win_cl  = (17'(win_q) > WinMax17) ? WinMax17 : 17'(win_q);
  assign eff_win = (win_cl < 17'(rwin_q)) ? 16'(win_cl) : rwin_q;
  assign ack_lim = ack_q + 32'(eff_win);

  // saturating counters
  assign retry_inc  = (retry_q == CountMax) ? retry_q : (retry_q + 1'b1);
  assign dup_inc    = (dup_q == CountMax) ? dup_q : (dup_q + 1'b1);
  assign retry_over = (retry_inc > max_retries_q);
  assign elapsed    = sat32(now_t - rd_data_q);

  // gains clamped to one
  assign gain_g = (rtt_gain_q > GainOne) ? GainOne : rtt_gain_q;
  assign inv_g  = GainOne - gain_g;
  assign gain_h = (dev_gain_q > GainOne) ? GainOne : dev_gain_q;
  assign inv_h  = GainOne - gain_h;

  // rounded blend of the two registered products
  assign blend_sum = 42'(pa_q) + 42'(pb_q) + 42'(RoundHalf);

  // rto from smoothed rtt and floored deviation
  assign floor_v = (dev_q > 32'(dev_floor_q)) ? dev_q : 32'(dev_floor_q);
  assign rto_w   = 35'(srtt_q) + {1'b0, floor_v, 2'b00};
  assign rto_sat = (rto_w[34:32] != '0) ? 32'hFFFF_FFFF : rto_w[31:0];

  // next state of the sender
  always_comb begin
    win_d         = win_q;
    max_retries_d = max_retries_q;
    rtt_gain_d    = rtt_gain_q;
    dev_gain_d    = dev_gain_q;
    dev_floor_d   = dev_floor_q;
    next_seq_d    = next_seq_q;
    base_seq_d    = base_seq_q;
    limit_d       = limit_q;
    srtt_d        = srtt_q;
    dev_d         = dev_q;
    rto_d         = rto_q;
    retry_d       = retry_q;
    dup_d         = dup_q;
    abort_d       = abort_q;
    next_slot_d   = next_slot_q;
    base_slot_d   = base_slot_q;
    act_d         = act_q;
    tx_d          = tx_q;
    refused_d     = refused_q;
    wr_en         = 1'b0;
    wr_addr       = base_slot_q;
    rd_en         = 1'b0;
    rd_addr       = base_slot_q;

    case (cmd_i.step)
      STEP_EXEC: begin
        act_d     = ACT_NONE;
        tx_d      = '0;
        refused_d = 1'b0;
        case (mode_q)
          MODE_SEND: begin
            if (!abort_q && (next_seq_q < limit_q)) begin
              wr_en       = 1'b1;
              wr_addr     = next_slot_q;
              act_d       = ACT_NEW;
              tx_d        = next_seq_q;
              next_seq_d  = next_seq_q + 1'b1;
              next_slot_d = (next_slot_q == LastSlot) ? '0 : (next_slot_q + 1'b1);
            end else begin
              refused_d = 1'b1;
            end
          end
          MODE_ACK: begin
            if (ack_q > base_seq_q) begin
              base_seq_d = ack_q;
              if (ack_lim > limit_q) limit_d = ack_lim;
            end else if (ack_q == base_seq_q) begin
              dup_d = dup_inc;
              // third duplicate triggers a fast retransmit of the base
              if (dup_inc == DupFastRtx) begin
                retry_d = retry_inc;
                abort_d = abort_q | retry_over;
                wr_en   = 1'b1;
                act_d   = ACT_FAST;
                tx_d    = base_seq_q;
              end
            end
          end
          MODE_TICK: begin
            rd_en = 1'b1;
          end
          default: ;
        endcase
      end
      STEP_TICK_CHK: begin
        if ((next_seq_q > base_seq_q) && (elapsed >= rto_q)) begin
          retry_d = retry_inc;
          abort_d = abort_q | retry_over;
          wr_en   = 1'b1;
          act_d   = ACT_TIMEOUT;
          tx_d    = base_seq_q;
        end
      end
      STEP_MOD_FIX: begin
        base_slot_d = SlotW'(rem_fix);
        retry_d     = '0;
        dup_d       = '0;
      end
      STEP_RTT_RD: begin
        rd_en   = 1'b1;
        rd_addr = prev_slot;
      end
      STEP_RTT_A1:  srtt_d = blend_sum[39:8];
      STEP_RTT_A2:  dev_d  = blend_sum[39:8];
      STEP_RTT_RTO: rto_d  = rto_sat;
      default: ;
    endcase

    // register writes, to be made by the user only while idle; the block itself does not enforce it
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WINDOW_SIZE:    win_d         = cfg_wdata_i[10:0];
        CFG_MAX_RETRIES:    max_retries_d = cfg_wdata_i[7:0];
        CFG_RTT_GAIN:       rtt_gain_d    = cfg_wdata_i[8:0];
        CFG_DEV_GAIN:       dev_gain_d    = cfg_wdata_i[8:0];
        CFG_DEV_FLOOR:      dev_floor_d   = cfg_wdata_i[19:0];
        CFG_INITIAL_RTO:    rto_d         = cfg_wdata_i;
        CFG_INITIAL_CREDIT: limit_d       = {21'd0, cfg_wdata_i[10:0]};
        default: ;
      endcase
    end
  end

  // sender state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q         <= WinSizeRst;
      max_retries_q <= MaxRetriesRst;
      rtt_gain_q    <= RttGainRst;
      dev_gain_q    <= DevGainRst;
      dev_floor_q   <= DevFloorRst;
      next_seq_q    <= '0;
      base_seq_q    <= '0;
      limit_q       <= {21'd0, InitCreditRst};
      srtt_q        <= '0;
      dev_q         <= '0;
      rto_q         <= InitRtoRst;
      retry_q       <= '0;
      dup_q         <= '0;
      abort_q       <= 1'b0;
      next_slot_q   <= '0;
      base_slot_q   <= '0;
    end else begin
      win_q         <= win_d;
      max_retries_q <= max_retries_d;
      rtt_gain_q    <= rtt_gain_d;
      dev_gain_q    <= dev_gain_d;
      dev_floor_q   <= dev_floor_d;
      next_seq_q    <= next_seq_d;
      base_seq_q    <= base_seq_d;
      limit_q       <= limit_d;
      srtt_q        <= srtt_d;
      dev_q         <= dev_d;
      rto_q         <= rto_d;
      retry_q       <= retry_d;
      dup_q         <= dup_d;
      abort_q       <= abort_d;
      next_slot_q   <= next_slot_d;
      base_slot_q   <= base_slot_d;
    end
  end

  // send time memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) send_times_q[wr_addr] <= now_t;
    if (rd_en) rd_data_q <= send_times_q[rd_addr];
  end

  // request latch, result fields and arithmetic pipeline registers
  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    tx_q      <= tx_d;
    refused_q <= refused_d;
    if (cmd_i.load) begin
      mode_q <= mode_e'(s_tuser_i);
      ack_q  <= s_tdata_i[31:0];
      rwin_q <= s_tdata_i[47:32];
      now_q  <= s_tdata_i[79:48];
    end
    case (cmd_i.step)
      STEP_MOD_MUL: quot_q   <= mod_prod[63:32];
      STEP_MOD_SUB: rem_q    <= RemW'(ack_q - quot_w);
      STEP_RTT_SMP: sample_q <= sat32(now_t - rd_data_q);
      STEP_RTT_M1: begin
        pa_q <= 41'(inv_g) * 41'(srtt_q);
        pb_q <= 41'(gain_g) * 41'(sample_q);
      end
      STEP_RTT_D1: begin
        diff_q <= (sample_q > srtt_q) ? (sample_q - srtt_q) : (srtt_q - sample_q);
      end
      STEP_RTT_M2: begin
        pa_q <= 41'(inv_h) * 41'(dev_q);
        pb_q <= 41'(gain_h) * 41'(diff_q);
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      m_tuser_o <= act_q;
      m_tdata_o <= {{PadW{1'b0}}, abort_q, rto_q, base_seq_q, refused_q, tx_q};
    end
  end

endmodule

### hw/rtl/sliding_window_sender_control.sv
// ----------------------------------------------------------------------------
// sliding_window_sender_control
// sender side control of a reliable sliding window transfer with fast
// retransmit, timeout retransmit and jacobson rtt/rto estimation
// ----------------------------------------------------------------------------
// Each request is one event (send, cumulative ack or time tick) and yields
// exactly one result. Requests are handled one at a time by a sequencer
// stepping a shared datapath; a finished result sits in an output register,
// so the next request is taken while it waits. A tick takes one registered
// read of the send time memory; a new ack is reduced to a memory slot by two
// multiply stages and, when it takes an rtt sample, then goes through a
// memory read, two rounds of multiply and add for the smoothed rtt and the
// deviation, and the rto sum. The send time memory has no reset and no
// clearing pass; only entries written earlier are ever used.
`include "sliding_window_sender_control_macros.svh"

module sliding_window_sender_control import swsc_pkg::*; #(
  parameter int unsigned WINDOW_MAX = WindowMaxDef,
  parameter int unsigned TIME_BITS  = TimeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // ack_seq[31:0], recv_window[47:32], now_us[79:48]
  input  logic [SDataW-1:0]   s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]          s_axis_tuser,
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tx_seq[31:0], send_refused[32], window_base[64:33], rto_us[96:65],
  // aborted[97], zero padding[103:98]
  output logic [MDataW-1:0]   m_axis_tdata,
  // action[1:0]
  output logic [1:0]          m_axis_tuser,
  // register write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  swsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  swsc_dp #(
    .WINDOW_MAX (WINDOW_MAX),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

  // one request in flight at a time
  `SWSC_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")

  // a refused send carries no action
  `SWSC_ASSERT_NOW(a_refused_no_action, m_axis_tvalid && m_axis_tdata[OutRefusedBit], m_axis_tuser == ACT_NONE, "refused send with action")

  // abort stays set once reported
  `SWSC_ASSERT_NEXT(a_abort_sticky, m_axis_tvalid && m_axis_tdata[OutAbortBit], m_axis_tdata[OutAbortBit], "abort flag cleared")

endmodule
